// ----- hdl/multi_queue_ring_fifo_macros.svh -----
// ---------------------------------------------------------------------------
// multi_queue_ring_fifo_macros.svh
// assertion helpers shared by the ring fifo bank
// ---------------------------------------------------------------------------
`ifndef MULTI_QUEUE_RING_FIFO_MACROS_SVH
`define MULTI_QUEUE_RING_FIFO_MACROS_SVH

// same-cycle implication, disabled while in reset
`define MQRF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mqrf same-cycle check failed");

// next-cycle implication, disabled while in reset
`define MQRF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mqrf next-cycle check failed");

`endif

// ----- hdl/mqrf_pkg.sv -----
// ---------------------------------------------------------------------------
// mqrf_pkg
// types and constants for the multi-queue ring fifo bank
// ---------------------------------------------------------------------------
package mqrf_pkg;

  // operation codes
  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_PUSH  = 2'd1;
  localparam logic [1:0] KIND_POP   = 2'd2;

  // result queue in the back part
  localparam int RQ_DEPTH = 4;
  localparam int RQ_AW    = 2;
  localparam int RQ_CW    = 3;

  // input item
  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  queue_index;
    logic [31:0] write_data;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [31:0] read_data;
    logic        was_empty;
    logic        was_full;
  } out_item_t;

  // classified operation handed from front to back
  typedef struct packed {
    logic valid;
    logic pop_ok;
    logic was_empty;
    logic was_full;
  } issue_t;

endpackage

// ----- hdl/mqrf_ram.sv -----
// ---------------------------------------------------------------------------
// mqrf_ram
// generic single write port ram with registered read
// ---------------------------------------------------------------------------
module mqrf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/mqrf_front.sv -----
// ---------------------------------------------------------------------------
// mqrf_front
// accepts items, checks head and tail, updates pointers, drives slot ram
// ---------------------------------------------------------------------------
module mqrf_front #(
  parameter int NUM_QUEUES = 8,
  parameter int DEPTH      = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     push,
  input  logic                                     busy,
  input  mqrf_pkg::in_item_t                       in_data,
  output mqrf_pkg::issue_t                         issue,
  output logic                                     ram_we,
  output logic [$clog2(NUM_QUEUES*DEPTH)-1:0]      ram_waddr,
  output logic [DATA_WIDTH-1:0]                    ram_wdata,
  output logic [$clog2(NUM_QUEUES*DEPTH)-1:0]      ram_raddr
);

  localparam int PW = $clog2(DEPTH);
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int AW = $clog2(NUM_QUEUES * DEPTH);

  logic [PW-1:0] head_r [NUM_QUEUES];
  logic [PW-1:0] tail_r [NUM_QUEUES];
  mqrf_pkg::issue_t issue_r;
  mqrf_pkg::issue_t issue_nxt;

  logic            accept;
  logic [QW+2:0]   q_ext;
  logic [QW-1:0]   qsel;
  logic            q_ok;
  logic [PW-1:0]   h;
  logic [PW-1:0]   t;
  logic [PW-1:0]   h_adv;
  logic [PW-1:0]   t_adv;
  logic            is_clear;
  logic            is_push;
  logic            is_pop;
  logic            push_ok;
  logic            pop_ok;
  logic [AW-1:0]   base;
  logic [DATA_WIDTH+31:0] wd_ext;

  assign accept = push && !busy;

  // queue select, indexes past the bank are ignored
  assign q_ext = {{QW{1'b0}}, in_data.queue_index};
  assign qsel  = q_ext[QW-1:0];
  assign q_ok  = (int'(q_ext) < NUM_QUEUES);

  // pointer lookup and wrap-around advance
  assign h     = head_r[qsel];
  assign t     = tail_r[qsel];
  assign h_adv = (h == PW'(DEPTH - 1)) ? '0 : h + PW'(1);
  assign t_adv = (t == PW'(DEPTH - 1)) ? '0 : t + PW'(1);

  // operation decode
  always_comb begin
    is_clear = 1'b0;
    is_push  = 1'b0;
    is_pop   = 1'b0;
    unique case (in_data.kind)
      mqrf_pkg::KIND_CLEAR: is_clear = accept && q_ok;
      mqrf_pkg::KIND_PUSH:  is_push  = accept && q_ok;
      mqrf_pkg::KIND_POP:   is_pop   = accept && q_ok;
      default: ;
    endcase
  end

  assign push_ok = is_push && (t_adv != h);
  assign pop_ok  = is_pop && (h != t);

  // classified item for the back part
  always_comb begin
    issue_nxt.valid     = accept;
    issue_nxt.pop_ok    = pop_ok;
    issue_nxt.was_empty = is_pop && (h == t);
    issue_nxt.was_full  = is_push && (t_adv == h);
  end

  // slot ram addressing, word masked to the stored width
  assign base      = AW'(qsel) * AW'(DEPTH);
  assign wd_ext    = {{DATA_WIDTH{1'b0}}, in_data.write_data};
  assign ram_we    = push_ok;
  assign ram_waddr = base + AW'(t);
  assign ram_raddr = base + AW'(h);
  assign ram_wdata = wd_ext[DATA_WIDTH-1:0];

  // pointer tables and issue register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
      end
      issue_r <= '0;
    end else begin
      if (is_clear) begin
        head_r[qsel] <= '0;
        tail_r[qsel] <= '0;
      end
      if (push_ok) begin
        tail_r[qsel] <= t_adv;
      end
      if (pop_ok) begin
        head_r[qsel] <= h_adv;
      end
      issue_r <= issue_nxt;
    end
  end

  assign issue = issue_r;

endmodule

// ----- hdl/mqrf_back.sv -----
// ---------------------------------------------------------------------------
// mqrf_back
// joins popped words with flags and holds results in a short queue
// ---------------------------------------------------------------------------
module mqrf_back #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mqrf_pkg::issue_t      issue,
  input  logic [DATA_WIDTH-1:0] ram_rdata,
  output logic                  busy,
  output logic                  empty,
  input  logic                  pop,
  output mqrf_pkg::out_item_t   out_data
);

  mqrf_pkg::out_item_t         rq_r [mqrf_pkg::RQ_DEPTH];
  logic [mqrf_pkg::RQ_AW-1:0]  wr_ptr_r;
  logic [mqrf_pkg::RQ_AW-1:0]  wr_ptr_nxt;
  logic [mqrf_pkg::RQ_AW-1:0]  rd_ptr_r;
  logic [mqrf_pkg::RQ_AW-1:0]  rd_ptr_nxt;
  logic [mqrf_pkg::RQ_CW-1:0]  cnt_r;
  logic [mqrf_pkg::RQ_CW-1:0]  cnt_nxt;
  logic [mqrf_pkg::RQ_CW-1:0]  pending;
  logic [DATA_WIDTH+31:0]      rd_ext;
  mqrf_pkg::out_item_t         entry;
  logic                        do_pop;

  // result item, word shown only for a pop that found data
  assign rd_ext = {32'b0, ram_rdata};
  always_comb begin
    entry.read_data = issue.pop_ok ? rd_ext[31:0] : 32'b0;
    entry.was_empty = issue.was_empty;
    entry.was_full  = issue.was_full;
  end

  // credit check counts the item in flight
  assign pending = cnt_r + mqrf_pkg::RQ_CW'(issue.valid);
  assign busy    = (pending >= mqrf_pkg::RQ_CW'(mqrf_pkg::RQ_DEPTH));

  assign empty  = (cnt_r == '0);
  assign do_pop = pop && !empty;

  // queue pointer and count update
  always_comb begin
    wr_ptr_nxt = issue.valid ? wr_ptr_r + mqrf_pkg::RQ_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + mqrf_pkg::RQ_AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + mqrf_pkg::RQ_CW'(issue.valid) - mqrf_pkg::RQ_CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // result storage
  always_ff @(posedge clk) begin
    if (issue.valid) begin
      rq_r[wr_ptr_r] <= entry;
    end
  end

  assign out_data = rq_r[rd_ptr_r];

endmodule

// ----- hdl/multi_queue_ring_fifo.sv -----
// an accepted item passes the issue register and the slot ram read register, then enters the result queue to be popped
// throughput: one item per cycle while full is low, set by the single slot ram port pair and pointer lookup
// full rises when the four-entry result queue plus the item in flight is full
// reset: synchronous, clears all head and tail pointers and the result queue
// slot storage is not cleared; only words from slots between head and tail are returned as read
// ---------------------------------------------------------------------------
// multi_queue_ring_fifo
// bank of independent ring fifos with clear, push and pop per item
// ---------------------------------------------------------------------------
`include "multi_queue_ring_fifo_macros.svh"

module multi_queue_ring_fifo #(
  parameter int NUM_QUEUES = 8,
  parameter int DEPTH      = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  mqrf_pkg::in_item_t  in_data,
  output logic                empty,
  input  logic                pop,
  output mqrf_pkg::out_item_t out_data
);

  localparam int AW = $clog2(NUM_QUEUES * DEPTH);

  mqrf_pkg::issue_t       issue;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [DATA_WIDTH-1:0]  ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [DATA_WIDTH-1:0]  ram_rdata;
  logic                   busy;

  // front: classify and update pointers
  mqrf_front #(
    .NUM_QUEUES (NUM_QUEUES),
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .busy      (busy),
    .in_data   (in_data),
    .issue     (issue),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr)
  );

  // slot storage for all queues
  mqrf_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (NUM_QUEUES * DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // back: result assembly and queue
  mqrf_back #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .issue     (issue),
    .ram_rdata (ram_rdata),
    .busy      (busy),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data)
  );

  assign full = busy;

  // checks
  `MQRF_ASSERT_NOW(a_flags_exclusive, clk, rst_n, !empty, !(out_data.was_empty && out_data.was_full))
  `MQRF_ASSERT_NOW(a_data_only_on_good_pop, clk, rst_n, !empty && (out_data.read_data != 32'b0), !out_data.was_empty && !out_data.was_full)
  `MQRF_ASSERT_NEXT(a_issue_lands, clk, rst_n, issue.valid, !empty)
  `MQRF_ASSERT_NOW(a_write_needs_issue, clk, rst_n, ram_we, push && !full)

endmodule
